// ===== design/rbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and fixed constants of the 2x2 RGBA box downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int unsigned CFG_W        = 13;   // width of a config register
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned ROW_W        = 12;   // row counter, heights up to 4096
    localparam int unsigned MID_DEPTH    = 4;    // front-to-back request queue
    localparam int unsigned OUT_DEPTH    = 4;    // result queue

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] SOURCE_WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RESET = 13'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT        = 13'd4096;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

    // per-channel horizontal pair sums
    typedef struct packed {
        logic [8:0] alpha;
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } t_hsum;

    // what the back end has to do with one request
    typedef struct packed {
        logic wr;     // store pair sum in the line store
        logic rd;     // emit, combining with the stored line
        logic last;   // final output pixel of the image
    } t_op_ctrl;

    typedef struct packed {
        logic  last;
        t_rgba pix;
    } t_pix_out;

endpackage
`default_nettype wire

// ===== design/rbd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/rbd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_fifo
// Small first-word-fall-through queue in flops.
// ----------------------------------------------------------------------------
module rbd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    input  wire logic                         i_pop,
    output logic      [WIDTH-1:0]             o_data,
    output logic                              o_empty,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CNTW-1:0]  r_count, n_count;
    logic             at_full;
    logic             do_push, do_pop;

    assign at_full = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !at_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/rbd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_front
// Frame position, config registers, left-pixel hold and pair sums; turns each
// accepted pixel into a line-store write, an emit request, or nothing.
// ----------------------------------------------------------------------------
module rbd_front #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [rbd_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  wire logic                                 i_accept,
    input  wire rbd_pkg::t_rgba                       i_pix,
    output logic                                      o_op_valid,
    output rbd_pkg::t_op_ctrl                         o_op_ctrl,
    output logic [((MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] o_op_idx,
    output rbd_pkg::t_hsum                            o_op_hsum
);

    import rbd_pkg::*;

    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CW = (WW > CFG_W) ? WW : CFG_W;

    function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [CW-1:0] v_ext;
        v_ext = CW'(v);
        if (v == '0) begin
            clamp_width = WW'(1);
        end else if (v_ext > CW'(MAX_WIDTH)) begin
            clamp_width = WW'(MAX_WIDTH);
        end else begin
            clamp_width = WW'(v_ext);
        end
    endfunction

    function automatic logic [CFG_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            clamp_height = CFG_W'(1);
        end else if (v > HEIGHT_LIMIT) begin
            clamp_height = HEIGHT_LIMIT;
        end else begin
            clamp_height = v;
        end
    endfunction

    logic [WW-1:0]    r_eff_w;
    logic [CFG_W-1:0] r_eff_h;
    logic [XW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_rgba            r_held;

    logic             w_one, h_one;
    logic             col_drop, row_drop, col_even, row_even;
    logic             have_pair, col_last, row_last;
    logic [WW-1:0]    col_ext;
    logic [CFG_W-1:0] row_ext;

    assign w_one    = (r_eff_w == WW'(1));
    assign h_one    = (r_eff_h == CFG_W'(1));
    assign col_ext  = WW'(r_col);
    assign row_ext  = CFG_W'(r_row);
    // odd sizes: last column / row gives nothing
    assign col_drop = !w_one && (col_ext >= (r_eff_w & ~WW'(1)));
    assign row_drop = !h_one && (row_ext >= (r_eff_h & ~CFG_W'(1)));
    assign col_even = !r_col[0];
    assign row_even = !r_row[0];
    assign have_pair = w_one || (!col_drop && !col_even);
    assign col_last = w_one || ((col_ext >> 1) == ((r_eff_w >> 1) - WW'(1)));
    assign row_last = h_one || ((row_ext >> 1) == ((r_eff_h >> 1) - CFG_W'(1)));

    always_comb begin
        if (w_one) begin
            o_op_hsum.red   = {i_pix.red,   1'b0};
            o_op_hsum.green = {i_pix.green, 1'b0};
            o_op_hsum.blue  = {i_pix.blue,  1'b0};
            o_op_hsum.alpha = {i_pix.alpha, 1'b0};
        end else begin
            o_op_hsum.red   = {1'b0, r_held.red}   + {1'b0, i_pix.red};
            o_op_hsum.green = {1'b0, r_held.green} + {1'b0, i_pix.green};
            o_op_hsum.blue  = {1'b0, r_held.blue}  + {1'b0, i_pix.blue};
            o_op_hsum.alpha = {1'b0, r_held.alpha} + {1'b0, i_pix.alpha};
        end
    end

    always_comb begin
        o_op_ctrl.wr   = 1'b0;
        o_op_ctrl.rd   = 1'b0;
        o_op_ctrl.last = col_last && row_last;
        o_op_valid     = 1'b0;
        if (i_accept && have_pair) begin
            if (h_one) begin
                o_op_valid = 1'b1;
            end else if (!row_drop) begin
                o_op_valid   = 1'b1;
                o_op_ctrl.wr = row_even;
                o_op_ctrl.rd = !row_even;
            end
        end
    end

    assign o_op_idx = IW'(r_col >> 1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if ((col_ext + WW'(1)) >= r_eff_w) begin
                n_col = '0;
                n_row = ((row_ext + CFG_W'(1)) >= r_eff_h) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= clamp_width(SOURCE_WIDTH_RESET);
            r_eff_h <= clamp_height(SOURCE_HEIGHT_RESET);
            r_col   <= '0;
            r_row   <= '0;
            r_held  <= '0;
        end else if (i_cfg_we) begin
            // any config write restarts the frame position
            case (i_cfg_idx)
                REG_SOURCE_WIDTH:  r_eff_w <= clamp_width(i_cfg_wdata);
                REG_SOURCE_HEIGHT: r_eff_h <= clamp_height(i_cfg_wdata);
                default:           r_eff_w <= r_eff_w;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_accept && !w_one && !col_drop && col_even) begin
                r_held <= i_pix;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/rbd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_back
// Executes requests: a line store write, or a rounded 2x2 average (reading the line store if needed).
// ----------------------------------------------------------------------------
module rbd_back #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_op_empty,
    input  wire rbd_pkg::t_op_ctrl                    i_op_ctrl,
    input  wire logic [((MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] i_op_idx,
    input  wire rbd_pkg::t_hsum                       i_op_hsum,
    output logic                                      o_op_pop,
    input  wire logic [$clog2(rbd_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                      o_out_push,
    output rbd_pkg::t_pix_out                         o_out_data
);

    import rbd_pkg::*;

    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned CNTW = $clog2(OUT_DEPTH + 1) + 1;

    logic     r_b_valid, r_b_rd, r_b_last;
    t_hsum    r_b_hsum;
    t_hsum    line_q, other;
    logic     room, issue, ram_we, ram_re;

    // reserve a result slot for the request in flight
    assign room     = (CNTW'(i_out_count) + CNTW'(r_b_valid)) < CNTW'(OUT_DEPTH);
    assign o_op_pop = room && !i_op_empty;
    assign issue    = o_op_pop;
    assign ram_we   = issue && i_op_ctrl.wr;
    assign ram_re   = issue && i_op_ctrl.rd;

    rbd_ram #(
        .WIDTH ($bits(t_hsum)),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_op_idx),
        .i_wdata (i_op_hsum),
        .i_re    (ram_re),
        .i_raddr (i_op_idx),
        .o_rdata (line_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= issue && !i_op_ctrl.wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_rd   <= i_op_ctrl.rd;
            r_b_last <= i_op_ctrl.last;
            r_b_hsum <= i_op_hsum;
        end
    end

    assign other = r_b_rd ? line_q : r_b_hsum;

    function automatic logic [7:0] avg4(input logic [8:0] a, input logic [8:0] b);
        logic [9:0] s;
        s = {1'b0, a} + {1'b0, b} + 10'd2;
        avg4 = s[9:2];
    endfunction

    assign o_out_push          = r_b_valid;
    assign o_out_data.last     = r_b_last;
    assign o_out_data.pix.red   = avg4(r_b_hsum.red,   other.red);
    assign o_out_data.pix.green = avg4(r_b_hsum.green, other.green);
    assign o_out_data.pix.blue  = avg4(r_b_hsum.blue,  other.blue);
    assign o_out_data.pix.alpha = avg4(r_b_hsum.alpha, other.alpha);

endmodule
`default_nettype wire

// ===== design/rgba_box_downscale_2x2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_box_downscale_2x2
// Half-size RGBA downscaler: rounded 2x2 box average over a raster stream.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// pixel in  input      push / full       i_red_in, i_green_in, i_blue_in, i_alpha_in
// result    output     empty / pop       o_red_out .. o_alpha_out, o_frame_last
// config    input      i_cfg_we          i_cfg_idx, i_cfg_wdata (13 bits)
//
// Sustained rate is one source pixel per clock while full is low; a result
// reaches the output by way of the request queue, then the line store read
// with the average into the result queue. Reset (i_rst_n low at a clock edge)
// restores 1024x1024 and frame position zero; the line store is not cleared.
// full rises only when the 4-entry request queue fills, i.e. when results
// are not being popped.
// ----------------------------------------------------------------------------
module rgba_box_downscale_2x2 #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rbd_pkg::CFG_W-1:0]     i_cfg_wdata,
    // source pixels
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    i_red_in,
    input  wire logic [7:0]                    i_green_in,
    input  wire logic [7:0]                    i_blue_in,
    input  wire logic [7:0]                    i_alpha_in,
    // downscaled pixels
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         o_red_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_blue_out,
    output logic [7:0]                         o_alpha_out,
    output logic                               o_frame_last
);

    import rbd_pkg::*;

    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned IW     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned MID_W  = $bits(t_op_ctrl) + IW + $bits(t_hsum);
    localparam int unsigned MID_CW = $clog2(MID_DEPTH + 1);

    // front -> request queue
    logic                          accept;
    t_rgba                         pix_in;
    logic                          op_valid;
    t_op_ctrl                      op_ctrl;
    logic [IW-1:0]                 op_idx;
    t_hsum                         op_hsum;

    // request queue -> back
    logic [MID_W-1:0]              mid_q;
    logic                          mid_full, mid_empty, mid_pop;
    logic [MID_CW-1:0]             mid_count;
    t_op_ctrl                      q_ctrl;
    logic [IW-1:0]                 q_idx;
    t_hsum                         q_hsum;

    // back -> result queue
    logic                          out_push;
    t_pix_out                      out_d, out_q;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    assign mid_full = (mid_count == MID_CW'(MID_DEPTH));
    assign full     = mid_full;
    assign accept   = push && !mid_full;

    assign pix_in.red   = i_red_in;
    assign pix_in.green = i_green_in;
    assign pix_in.blue  = i_blue_in;
    assign pix_in.alpha = i_alpha_in;

    rbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_pix       (pix_in),
        .o_op_valid  (op_valid),
        .o_op_ctrl   (op_ctrl),
        .o_op_idx    (op_idx),
        .o_op_hsum   (op_hsum)
    );

    // only pixels that write the line store or emit a result are queued
    rbd_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_valid),
        .i_data  ({op_ctrl, op_idx, op_hsum}),
        .i_pop   (mid_pop),
        .o_data  (mid_q),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign {q_ctrl, q_idx, q_hsum} = mid_q;

    rbd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_empty  (mid_empty),
        .i_op_ctrl   (q_ctrl),
        .i_op_idx    (q_idx),
        .i_op_hsum   (q_hsum),
        .o_op_pop    (mid_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_d)
    );

    // back end reserves space, so a push never meets a full queue
    rbd_fifo #(
        .WIDTH ($bits(t_pix_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_d),
        .i_pop   (pop),
        .o_data  (out_q),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_red_out    = out_q.pix.red;
    assign o_green_out  = out_q.pix.green;
    assign o_blue_out   = out_q.pix.blue;
    assign o_alpha_out  = out_q.pix.alpha;
    assign o_frame_last = out_q.last;

endmodule
`default_nettype wire

// ===== verif/rgba_box_downscale_2x2_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgba_box_downscale_2x2_tb
// Self-checking bench for the 2x2 RGBA box downscaler. Source pixels are
// pushed in raster order and a cycle-free predictor works out each averaged
// output pixel. Popped results are checked in order against it. Frame sizes
// cover one pixel, odd sizes, reused single rows and columns, and both
// saturated maxima. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module rgba_box_downscale_2x2_tb;
    import rbd_pkg::*;

    localparam int unsigned LINE_PX_MAX   = 4096;     // DUT line store sizing
    localparam int unsigned HEIGHT_MAX    = 4096;
    localparam int unsigned SETTLE_CYCLES = 16;       // queue + line store + average
    localparam int unsigned HOLD_CYCLES   = 80;       // long receiver hold-off
    localparam int unsigned RANDOM_ITEMS  = 556;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;   // watchdog limit in ns

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [7:0]           i_red_in    = '0;
    logic [7:0]           i_green_in  = '0;
    logic [7:0]           i_blue_in   = '0;
    logic [7:0]           i_alpha_in  = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [7:0]           o_red_out;
    logic [7:0]           o_green_out;
    logic [7:0]           o_blue_out;
    logic [7:0]           o_alpha_out;
    logic                 o_frame_last;

    rgba_box_downscale_2x2 #(
        .MAX_WIDTH(LINE_PX_MAX)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_alpha_in  (i_alpha_in),
        .empty       (empty),
        .pop         (pop),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_alpha_out (o_alpha_out),
        .o_frame_last(o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block's registers, frame position,
    // held left pixel and the even-row pair sum line.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] model_width  = SOURCE_WIDTH_RESET;
    logic [CFG_W-1:0] model_height = SOURCE_HEIGHT_RESET;
    int unsigned      px_col       = 0;
    int unsigned      px_row       = 0;
    t_rgba            held_px      = '0;
    t_hsum            pair_line [LINE_PX_MAX/2];

    t_pix_out         downscaled_q [$];   // averaged pixels still owed by the DUT
    t_rgba            source_px_q  [$];   // pixels waiting to be pushed

    // bench control, written at rising edges, read by the drivers at falling ones
    int unsigned      tx_idle_pct    = 0;
    int unsigned      rx_stall_pct   = 0;
    logic             hold_rx        = 1'b0;
    logic             px_taken       = 1'b0;
    int unsigned      mismatch_count = 0;
    event             hold_start;

    // rounded mean of two pair sums (four pixels)
    function automatic logic [7:0] avg4(logic [8:0] s0, logic [8:0] s1);
        logic [10:0] total;
        total = s0 + s1 + 11'd2;
        return total[9:2];
    endfunction

    // raster position step with wrap at end of image
    function automatic void move_on(int unsigned w, int unsigned h);
        px_col++;
        if (px_col >= w) begin
            px_col = 0;
            px_row++;
            if (px_row >= h) px_row = 0;
        end
    endfunction

    // a register write restarts the frame; held pixel and line store stay
    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        if (idx == REG_SOURCE_WIDTH) model_width = value;
        else model_height = value;
        px_col = 0;
        px_row = 0;
    endfunction

    function automatic void add_px(t_rgba px);
        source_px_q.insert(source_px_q.size(), px);
    endfunction

    function automatic void downscale_pixel(t_rgba px);
        int unsigned w, h, nw, nh, idx;
        t_hsum       pair, other;
        t_pix_out    res;
        // zero means one, oversize saturates
        w   = (model_width == 0) ? 1 : (model_width > LINE_PX_MAX) ? LINE_PX_MAX : model_width;
        h   = (model_height == 0) ? 1 : (model_height > HEIGHT_MAX) ? HEIGHT_MAX : model_height;
        nw  = (w > 1) ? w / 2 : 1;
        nh  = (h > 1) ? h / 2 : 1;
        idx = px_col / 2;

        // horizontal pairing: single column is doubled, odd last column dropped
        if (w == 1) begin
            pair.red   = {px.red,   1'b0};
            pair.green = {px.green, 1'b0};
            pair.blue  = {px.blue,  1'b0};
            pair.alpha = {px.alpha, 1'b0};
        end else if (px_col >= 2 * nw) begin
            move_on(w, h);
            return;
        end else if (px_col % 2 == 0) begin
            held_px = px;
            move_on(w, h);
            return;
        end else begin
            pair.red   = held_px.red   + px.red;
            pair.green = held_px.green + px.green;
            pair.blue  = held_px.blue  + px.blue;
            pair.alpha = held_px.alpha + px.alpha;
        end

        // vertical pairing: single row is doubled, odd last row dropped
        if (h == 1) begin
            other = pair;
        end else if (px_row >= 2 * nh) begin
            move_on(w, h);
            return;
        end else if (px_row % 2 == 0) begin
            pair_line[idx] = pair;
            move_on(w, h);
            return;
        end else begin
            other = pair_line[idx];
        end

        res.pix.red   = avg4(pair.red,   other.red);
        res.pix.green = avg4(pair.green, other.green);
        res.pix.blue  = avg4(pair.blue,  other.blue);
        res.pix.alpha = avg4(pair.alpha, other.alpha);
        res.last      = (idx == nw - 1) && (px_row / 2 == nh - 1);
        downscaled_q.insert(downscaled_q.size(), res);
        move_on(w, h);
    endfunction

    // ------------------------------------------------------------------
    // Input side: sample the request at the rising edge, drive at the falling
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        px_taken = i_rst_n && push && !full;
        if (px_taken)
            downscale_pixel('{alpha: i_alpha_in, blue: i_blue_in,
                              green: i_green_in, red: i_red_in});
    end

    // a request stays up until taken; only then may the sender go idle
    always @(negedge i_clk) begin : feed_pixels
        t_rgba next_px;
        if (!push || px_taken) begin
            if (i_rst_n && source_px_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_px    = source_px_q.pop_front();
                push       <= 1'b1;
                i_red_in   <= next_px.red;
                i_green_in <= next_px.green;
                i_blue_in  <= next_px.blue;
                i_alpha_in <= next_px.alpha;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, plus a long hold to back the DUT up
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rx)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    // long receiver hold-off, counted in clock cycles
    always begin : rx_hold
        @(hold_start);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    always @(posedge i_clk) begin : check_results
        t_pix_out got, want;
        if (i_rst_n && pop && !empty) begin
            got.last      = o_frame_last;
            got.pix.red   = o_red_out;
            got.pix.green = o_green_out;
            got.pix.blue  = o_blue_out;
            got.pix.alpha = o_alpha_out;
            if (downscaled_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d last=%0b",
                             $time, got.pix.red, got.pix.green, got.pix.blue,
                             got.pix.alpha, got.last);
            end else begin
                want = downscaled_q.pop_front();
                if (got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
                    got.pix.blue !== want.pix.blue || got.pix.alpha !== want.pix.alpha ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch exp r=%0d g=%0d b=%0d a=%0d last=%0b,",
                                  " got r=%0d g=%0d b=%0d a=%0d last=%0b"},
                                 $time, want.pix.red, want.pix.green, want.pix.blue,
                                 want.pix.alpha, want.last, got.pix.red, got.pix.green,
                                 got.pix.blue, got.pix.alpha, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // all pixels pushed and all results popped, then let dropped pixels settle
    task automatic wait_idle();
        @(negedge i_clk);
        while (source_px_q.size() != 0 || push || downscaled_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one-cycle register write; returns on a rising edge
    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        apply_setting(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic new_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, t_idle_mode mode);
        wait_idle();
        write_setting(REG_SOURCE_WIDTH, w);
        write_setting(REG_SOURCE_HEIGHT, h);
        tx_idle_pct  = (mode == IDLE_SENDER)   ? 53 : (mode == IDLE_BOTH) ? 25 : 0;
        rx_stall_pct = (mode == IDLE_RECEIVER) ? 53 : (mode == IDLE_BOTH) ? 25 : 0;
    endtask

    task automatic queue_random(int unsigned n);
        repeat (n) add_px(t_rgba'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned      sent, k, n, wn, hn;
        logic [CFG_W-1:0] w, h;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2x2: saturated channels, then a rounding mix of zeros and full scale
        new_phase(2, 2, IDLE_NONE);
        repeat (4) add_px(32'hFFFF_FFFF);
        add_px(32'hFF00_FF00);
        add_px(32'h00FF_00FF);
        add_px(32'h0101_0203);
        add_px(32'h0001_0001);

        // zero size means one: 1x1 frames pass straight through
        new_phase(0, 0, IDLE_NONE);
        add_px(32'hA5C3_0F81);
        add_px(32'h5A3C_F07E);

        // odd width with a single row, odd height with a single column
        new_phase(3, 1, IDLE_NONE);
        queue_random(3);
        new_phase(1, 3, IDLE_NONE);
        queue_random(3);

        // one column reused twice, one row reused twice
        new_phase(1, 2, IDLE_NONE);
        queue_random(2);
        new_phase(2, 1, IDLE_NONE);
        queue_random(2);

        // rewriting a register mid-frame restarts at the top-left pixel
        new_phase(2, 2, IDLE_NONE);
        queue_random(2);
        wait_idle();
        write_setting(REG_SOURCE_HEIGHT, 2);
        queue_random(4);

        // saturated width, start of a single row
        new_phase(8191, 1, IDLE_BOTH);
        queue_random(64);

        // saturated height in a single column, first rows
        new_phase(0, 8191, IDLE_RECEIVER);
        queue_random(64);

        // every pixel is a result: output held while the sender keeps going
        new_phase(1, 1, IDLE_NONE);
        -> hold_start;
        queue_random(40);

        // random small frames, mostly complete, sometimes cut short
        sent = 0;
        k    = 0;
        while (sent < RANDOM_ITEMS) begin
            w  = CFG_W'(($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 9));
            h  = CFG_W'($urandom_range(0, 6));
            wn = (w == 0) ? 1 : w;
            hn = (h == 0) ? 1 : h;
            new_phase(w, h, t_idle_mode'(k % 4));
            n = wn * hn * $urandom_range(1, 3);
            if ($urandom_range(3) == 0) n += $urandom_range(0, wn * hn - 1);
            if (k % 5 == 0) begin
                // enough traffic to fill both DUT queues while the output is held
                while (n < 40) n += wn * hn;
            end
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            if (k % 5 == 0) -> hold_start;
            queue_random(n);
            sent += n;
            k++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("** rgba_box_downscale_2x2: PASSED **");
        else
            $display("** rgba_box_downscale_2x2: FAILED **");
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("** rgba_box_downscale_2x2: FAILED **");
        $finish;
    end

endmodule
